/* rtl/stbs_pkg.sv */
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Fixed field widths of the request and result ports
  localparam int SIZE_W = 11;
  localparam int LIDX_W = 10;
  localparam int KEY_W  = 32;
  localparam int POS_W  = 10;

  // Compare width covers both the key and a sign-extended entry
  localparam int CMP_W = (ENTRY_WIDTH > KEY_W) ? ENTRY_WIDTH : KEY_W;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SEARCH = 1'b1
  } req_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    req_e                     req;
    logic [LIDX_W-1:0]        load_index;
    logic signed [KEY_W-1:0]  load_value;
    logic signed [KEY_W-1:0]  search_key;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

/* rtl/stbs_front.sv */
module stbs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            req_type_i,
  input  logic [stbs_pkg::LIDX_W-1:0]     load_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] load_value_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] search_key_i,
  output logic                            busy,
  input  logic                            pop_i,
  output stbs_pkg::queue_head_t           head_o
);

  stbs_pkg::item_t                    queue_q [stbs_pkg::QUEUE_DEPTH];
  logic [stbs_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [stbs_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [stbs_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic                               push;
  stbs_pkg::item_t                    item_in;

  // Stall the requester while the queue is full
  assign busy = (cnt_q == stbs_pkg::QCNT_W'(stbs_pkg::QUEUE_DEPTH));
  assign push = start && !busy;

  // Classify the incoming request
  always_comb begin
    item_in.req        = stbs_pkg::req_e'(req_type_i);
    item_in.load_index = load_index_i;
    item_in.load_value = load_value_i;
    item_in.search_key = search_key_i;
  end

  // Advance pointers with wrap and track fill
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == stbs_pkg::QPTR_W'(stbs_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == stbs_pkg::QPTR_W'(stbs_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = queue_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stbs_pkg::QCNT_W'(stbs_pkg::QUEUE_DEPTH))
    else $error("queue fill count above depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with mismatched pointers");
`endif

endmodule

/* rtl/stbs_back.sv */
module stbs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          table_size_we_i,
  input  logic [stbs_pkg::SIZE_W-1:0]   table_size_i,
  input  stbs_pkg::queue_head_t         head_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic                          found_o,
  output logic [stbs_pkg::POS_W-1:0]    position_o
);

  localparam int IW = stbs_pkg::IDX_W;

  stbs_pkg::state_e                   state_q, state_d;
  logic [stbs_pkg::SIZE_W-1:0]        size_q;
  logic [IW-1:0]                      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [stbs_pkg::KEY_W-1:0]  key_q, key_d;
  logic                               done_q, done_d, found_q, found_d;
  logic [stbs_pkg::POS_W-1:0]         pos_q, pos_d;

  logic [stbs_pkg::ENTRY_WIDTH-1:0]   table_mem [stbs_pkg::TABLE_DEPTH];
  logic [stbs_pkg::ENTRY_WIDTH-1:0]   rd_q;
  logic [IW-1:0]                      raddr, waddr;
  logic [stbs_pkg::ENTRY_WIDTH-1:0]   wdata;
  logic                               we;

  logic [IW:0]                        cnt;
  logic                               empty;
  logic [IW-1:0]                      first_hi;
  logic signed [stbs_pkg::CMP_W-1:0]  entry_ext, key_ext;
  logic                               is_eq, is_gt;
  logic                               pop_search;
  logic [IW:0]                        mid_sum;

  // Clamp the entry count to the table depth
  always_comb begin
    if (int'(size_q) > stbs_pkg::TABLE_DEPTH) begin
      cnt = (IW+1)'(stbs_pkg::TABLE_DEPTH);
    end else begin
      cnt = (IW+1)'(size_q);
    end
    empty    = (cnt == '0);
    first_hi = IW'(cnt - 1'b1);
  end

  // Compare probed entry with the key, both sign-extended
  assign entry_ext = stbs_pkg::CMP_W'(signed'(rd_q));
  assign key_ext   = stbs_pkg::CMP_W'(key_q);
  assign is_eq     = (key_ext == entry_ext);
  assign is_gt     = (key_ext > entry_ext);

  assign pop_o      = (state_q == stbs_pkg::ST_IDLE) && head_i.valid;
  assign pop_search = pop_o && (head_i.item.req == stbs_pkg::REQ_SEARCH);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (pop_search && !empty) begin
          state_d = stbs_pkg::ST_SEARCH;
        end
      end
      stbs_pkg::ST_SEARCH: begin
        if (is_eq || (is_gt && mid_q == hi_q) || (!is_gt && mid_q == lo_q)) begin
          state_d = stbs_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Bounds, probe address, table writes and result
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    key_d   = key_q;
    done_d  = 1'b0;
    found_d = 1'b0;
    pos_d   = '0;
    we      = 1'b0;
    waddr   = IW'(head_i.item.load_index);
    wdata   = stbs_pkg::ENTRY_WIDTH'(head_i.item.load_value);
    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (pop_o && head_i.item.req == stbs_pkg::REQ_LOAD) begin
          we = (int'(head_i.item.load_index) < stbs_pkg::TABLE_DEPTH);
        end
        if (pop_search) begin
          key_d = head_i.item.search_key;
          lo_d  = '0;
          hi_d  = first_hi;
          if (empty) begin
            done_d = 1'b1;
          end
        end
      end
      stbs_pkg::ST_SEARCH: begin
        if (is_eq) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = stbs_pkg::POS_W'(mid_q);
        end else if (is_gt) begin
          if (mid_q == hi_q) begin
            done_d = 1'b1;
          end else begin
            lo_d = mid_q + 1'b1;
          end
        end else begin
          if (mid_q == lo_q) begin
            done_d = 1'b1;
          end else begin
            hi_d = mid_q - 1'b1;
          end
        end
      end
    endcase
    mid_sum = {1'b0, lo_d} + {1'b0, hi_d};
    mid_d   = mid_sum[IW:1];
    raddr   = mid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbs_pkg::ST_IDLE;
      size_q  <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      found_q <= found_d;
      if (table_size_we_i) begin
        size_q <= table_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
    pos_q <= pos_d;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    rd_q <= table_mem[raddr];
  end

  assign done_o     = done_q;
  assign found_o    = found_q;
  assign position_o = pos_q;

`ifndef SYNTHESIS
  a_miss_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !found_q) |-> pos_q == '0)
    else $error("miss result with nonzero position");
  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stbs_pkg::ST_SEARCH) |-> (lo_q <= hi_q))
    else $error("search bounds crossed while searching");
  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stbs_pkg::ST_SEARCH) |-> (mid_q >= lo_q && mid_q <= hi_q))
    else $error("probe outside search bounds");
  a_hit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stbs_pkg::ST_SEARCH && is_eq) |=> (done_q && found_q))
    else $error("hit did not produce a found result");
`endif

endmodule

/* rtl/sorted_table_binary_search.sv */
// Search: a request waits in the queue and is popped when the back end is idle; each probe reads
// the table's registered read port (at most 11 probes at depth 1024); an empty table answers without a probe.
// Pops occur only while idle: a search ends before the next starts; a load writes the table on pop.
// A two-entry request queue takes items while a search runs; busy rises when it is full.
// Results are strobed for one cycle on done_o; the receiver cannot stall them.
// Reset clears table_size, the queue and the search engine; table contents stay undefined.
module sorted_table_binary_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type_i,
  input  logic [stbs_pkg::LIDX_W-1:0]       load_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] load_value_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] search_key_i,
  input  logic                              table_size_we_i,
  input  logic [stbs_pkg::SIZE_W-1:0]       table_size_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic [stbs_pkg::POS_W-1:0]        position_o
);

  stbs_pkg::queue_head_t head;
  logic                  pop;

  // Accept and queue requests
  stbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .req_type_i   (req_type_i),
    .load_index_i (load_index_i),
    .load_value_i (load_value_i),
    .search_key_i (search_key_i),
    .busy         (busy),
    .pop_i        (pop),
    .head_o       (head)
  );

  // Load the table and run searches
  stbs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .table_size_we_i (table_size_we_i),
    .table_size_i    (table_size_i),
    .head_i          (head),
    .pop_o           (pop),
    .done_o          (done_o),
    .found_o         (found_o),
    .position_o      (position_o)
  );

endmodule

/* tb/sorted_table_binary_search_test.sv */
module sorted_table_binary_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_ITEMS = 360;
  localparam int SPINE_STEP   = 4096;

  localparam logic signed [stbs_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [stbs_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    ROW_SIZE,
    ROW_LOAD,
    ROW_SEARCH
  } row_kind_e;

  // One line of the directed plan; pinned rows carry a hand-written outcome
  typedef struct packed {
    row_kind_e                         kind;
    logic [stbs_pkg::SIZE_W-1:0]       arg;
    logic signed [stbs_pkg::KEY_W-1:0] val;
    logic                              pinned;
    logic                              pin_hit;
    logic [stbs_pkg::POS_W-1:0]        pin_at;
  } plan_row_t;

  typedef struct {
    logic                       found;
    logic [stbs_pkg::POS_W-1:0] position;
  } lookup_t;

  localparam int PLAN_LEN = 21;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic                              req_type_i;
  logic [stbs_pkg::LIDX_W-1:0]       load_index_i;
  logic signed [stbs_pkg::KEY_W-1:0] load_value_i;
  logic signed [stbs_pkg::KEY_W-1:0] search_key_i;
  logic                              table_size_we_i;
  logic [stbs_pkg::SIZE_W-1:0]       table_size_i;
  logic                              done_o;
  logic                              found_o;
  logic [stbs_pkg::POS_W-1:0]        position_o;

  // Hand-written outcome that travels with the current request
  logic                       pin_valid;
  logic                       pin_found;
  logic [stbs_pkg::POS_W-1:0] pin_pos;

  // Shadow of the block: table contents and active size
  logic signed [stbs_pkg::KEY_W-1:0] table_img [stbs_pkg::TABLE_DEPTH];
  int unsigned                       size_img = 0;

  lookup_t   lookup_q [$];
  plan_row_t plan [PLAN_LEN];
  int        errors      = 0;
  int        cycle_cnt   = 0;
  int        items_sent  = 0;
  bit        burst_mode  = 0;

  sorted_table_binary_search u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .load_index_i   (load_index_i),
    .load_value_i   (load_value_i),
    .search_key_i   (search_key_i),
    .table_size_we_i(table_size_we_i),
    .table_size_i   (table_size_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .position_o     (position_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Binary search over the shadow table, lower midpoint, stop on match or crossed bounds
  function automatic lookup_t binary_lookup(logic signed [stbs_pkg::KEY_W-1:0] key);
    lookup_t res;
    int      lo;
    int      hi;
    int      mid;
    res.found    = 1'b0;
    res.position = '0;
    lo = 0;
    hi = int'(size_img) - 1;
    while (!res.found && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (table_img[mid] == key) begin
        res.found    = 1'b1;
        res.position = mid[stbs_pkg::POS_W-1:0];
      end else if (key > table_img[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  // Sorted value for a given index of a full-depth table
  function automatic logic signed [stbs_pkg::KEY_W-1:0] spine_value(int idx);
    return stbs_pkg::KEY_W'((idx - stbs_pkg::TABLE_DEPTH / 2) * SPINE_STEP);
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= REPORT_MAX) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Check result strobes, track size writes, predict every accepted search and mirror every accepted load
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (lookup_q.size() == 0) begin
          flag_error($sformatf("result with no search outstanding: found=%0b pos=%0d",
                               found_o, position_o));
        end else begin
          want = lookup_q.pop_front();
          if (found_o !== want.found || position_o !== want.position) begin
            flag_error($sformatf({"lookup mismatch: expected found=%0b pos=%0d, ",
                                  "got found=%0b pos=%0d"},
                                 want.found, want.position, found_o, position_o));
          end
        end
      end
      if (table_size_we_i) begin
        size_img = (int'(table_size_i) > stbs_pkg::TABLE_DEPTH) ?
                   stbs_pkg::TABLE_DEPTH : int'(table_size_i);
      end
      if (start && !busy) begin
        if (req_type_i == stbs_pkg::REQ_SEARCH) begin
          want = binary_lookup(search_key_i);
          if (pin_valid) begin
            want.found    = pin_found;
            want.position = pin_pos;
          end
          lookup_q.push_back(want);
        end else begin
          table_img[load_index_i] = load_value_i;
        end
      end
    end
  end

  // Present one request, hold it until the block takes it, then maybe idle
  task automatic transfer(stbs_pkg::req_e kind, logic [stbs_pkg::LIDX_W-1:0] idx,
                          logic signed [stbs_pkg::KEY_W-1:0] val,
                          logic signed [stbs_pkg::KEY_W-1:0] key, logic pinned, logic hit,
                          logic [stbs_pkg::POS_W-1:0] at);
    int r;
    int gap;
    start        <= 1'b1;
    req_type_i   <= kind;
    load_index_i <= idx;
    load_value_i <= val;
    search_key_i <= key;
    pin_valid    <= pinned;
    pin_found    <= hit;
    pin_pos      <= at;
    do @(posedge clk_i); while (busy);
    items_sent++;
    gap = 0;
    if (!burst_mode) begin
      r = $urandom_range(99, 0);
      if (r >= 90) begin
        gap = $urandom_range(40, 8);
      end else if (r >= 45) begin
        gap = $urandom_range(3, 1);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_entry(logic [stbs_pkg::LIDX_W-1:0] idx,
                            logic signed [stbs_pkg::KEY_W-1:0] val);
    transfer(stbs_pkg::REQ_LOAD, idx, val, $urandom, 1'b0, 1'b0, '0);
  endtask

  task automatic search_for(logic signed [stbs_pkg::KEY_W-1:0] key);
    transfer(stbs_pkg::REQ_SEARCH, stbs_pkg::LIDX_W'($urandom), $urandom, key,
             1'b0, 1'b0, '0);
  endtask

  // Drop start, let the last transfer reach the predictor, then wait out every result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(int unsigned n);
    settle();
    table_size_we_i <= 1'b1;
    table_size_i    <= stbs_pkg::SIZE_W'(n);
    @(posedge clk_i);
    table_size_we_i <= 1'b0;
  endtask

  // Load entries 0..count-1 with a non-decreasing run, saturated at the top
  task automatic fill_ascending(int count, longint base, int unsigned step_max);
    longint acc;
    acc = base;
    for (int i = 0; i < count; i++) begin
      load_entry(stbs_pkg::LIDX_W'(i), (acc > KEY_MAX) ? KEY_MAX : stbs_pkg::KEY_W'(acc));
      acc += longint'($urandom_range(step_max, 0));
    end
  endtask

  // Load both outer probe paths of a full-depth table and search along them,
  // at full depth and with an oversized table_size
  task automatic spine_phase();
    int lo;
    int hi;
    int mid;
    int path_q [$];
    for (int side = 0; side < 2; side++) begin
      lo = 0;
      hi = stbs_pkg::TABLE_DEPTH - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        path_q.push_back(mid);
        if (side == 0) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
    end
    foreach (path_q[i]) begin
      load_entry(stbs_pkg::LIDX_W'(path_q[i]), spine_value(path_q[i]));
    end
    for (int pass = 0; pass < 2; pass++) begin
      write_size((pass == 0) ? stbs_pkg::TABLE_DEPTH : (1 << stbs_pkg::SIZE_W) - 1);
      foreach (path_q[i]) begin
        search_for(spine_value(path_q[i]));
      end
      search_for(KEY_MIN);
      search_for(KEY_MAX);
    end
  endtask

  // Mostly lookups of stored entries and near misses, some extremes, random keys and a few random loads
  task automatic search_burst(int count);
    int                                r;
    int unsigned                       active;
    logic signed [stbs_pkg::KEY_W-1:0] pick;
    burst_mode = ($urandom_range(3, 0) == 0);
    active     = size_img;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99, 0);
      if (r < 8) begin
        load_entry(stbs_pkg::LIDX_W'($urandom), $urandom);
      end else begin
        if (active > 0 && r < 60) begin
          pick = table_img[$urandom_range(active - 1, 0)];
          if (r >= 45) begin
            pick = $urandom_range(1, 0) ? pick + 1 : pick - 1;
          end
        end else if (r < 75) begin
          case ($urandom_range(3, 0))
            0:       pick = KEY_MIN;
            1:       pick = KEY_MAX;
            2:       pick = '0;
            default: pick = -32'sd1;
          endcase
        end else begin
          pick = $urandom;
        end
        search_for(pick);
      end
    end
    burst_mode = 0;
  endtask

  initial begin
    longint      base;
    int unsigned step_max;
    int          target;
    plan = '{
      // empty table straight out of reset
      '{ROW_SEARCH, 11'd0,    32'sd0,  1'b1, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd0,    KEY_MIN, 1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd1,    -32'sd5, 1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd2,    32'sd0,  1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd3,    32'sd7,  1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd4,    KEY_MAX, 1'b0, 1'b0, 10'd0},
      '{ROW_LOAD,   11'd1023, KEY_MAX, 1'b0, 1'b0, 10'd0},
      '{ROW_SIZE,   11'd5,    32'sd0,  1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    KEY_MIN, 1'b1, 1'b1, 10'd0},
      '{ROW_SEARCH, 11'd0,    KEY_MAX, 1'b1, 1'b1, 10'd4},
      '{ROW_SEARCH, 11'd0,    32'sd0,  1'b1, 1'b1, 10'd2},
      '{ROW_SEARCH, 11'd0,    -32'sd5, 1'b1, 1'b1, 10'd1},
      '{ROW_SEARCH, 11'd0,    32'sd7,  1'b1, 1'b1, 10'd3},
      // misses between stored values
      '{ROW_SEARCH, 11'd0,    32'sd6,  1'b1, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    KEY_MIN + 1, 1'b1, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    32'sd1,  1'b0, 1'b0, 10'd0},
      // single-entry table
      '{ROW_SIZE,   11'd1,    32'sd0,  1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    KEY_MIN, 1'b1, 1'b1, 10'd0},
      '{ROW_SEARCH, 11'd0,    32'sd5,  1'b1, 1'b0, 10'd0},
      // size written back to zero
      '{ROW_SIZE,   11'd0,    32'sd0,  1'b0, 1'b0, 10'd0},
      '{ROW_SEARCH, 11'd0,    KEY_MIN, 1'b1, 1'b0, 10'd0}
    };

    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = 1'b0;
    load_index_i    = '0;
    load_value_i    = '0;
    search_key_i    = '0;
    table_size_we_i = 1'b0;
    table_size_i    = '0;
    pin_valid       = 1'b0;
    pin_found       = 1'b0;
    pin_pos         = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan
    for (int i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].kind)
        ROW_SIZE: begin
          write_size(plan[i].arg);
        end
        ROW_LOAD: begin
          load_entry(plan[i].arg[stbs_pkg::LIDX_W-1:0], plan[i].val);
        end
        default: begin
          transfer(stbs_pkg::REQ_SEARCH, stbs_pkg::LIDX_W'($urandom), $urandom,
                   plan[i].val, plan[i].pinned, plan[i].pin_hit, plan[i].pin_at);
        end
      endcase
    end

    // Deepest searches: full depth and saturated size over the outer probe paths
    spine_phase();
    target = items_sent + RANDOM_ITEMS;

    // Small sorted tables with fresh content each phase
    while (items_sent < target) begin
      case ($urandom_range(3, 0))
        0:       step_max = 3;
        1:       step_max = 1000;
        2:       step_max = 32'd1 << 20;
        default: step_max = 32'd1 << 26;
      endcase
      base = longint'($signed($urandom)) >>> $urandom_range(31, 0);
      write_size($urandom_range(48, 0));
      fill_ascending(int'(size_img), base, step_max);
      search_burst($urandom_range(40, 10));
    end

    settle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
